[rtl/three_channel_pit_sound_top_defines.svh]
// Assertion macros for the three-channel interval timer tone source.
`ifndef THREE_CHANNEL_PIT_SOUND_TOP_DEFINES_SVH
`define THREE_CHANNEL_PIT_SOUND_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TCPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcps: assertion failed");
`define TCPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcps: assertion failed");
`else
`define TCPS_ASSERT_IMP(lbl, ante, cons)
`define TCPS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/tcps_pkg.sv]
// Shared types and codes of the three-channel interval timer tone source.
`timescale 1ns / 1ps

package tcps_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned GainW   = 14;

  localparam logic [GainW-1:0] GainReset = 14'd3584;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Decoded ports
  localparam logic [7:0] PORT_ENABLE = 8'h02;
  localparam logic [7:0] PORT_CNT0   = 8'h0c;
  localparam logic [7:0] PORT_CNT1   = 8'h0d;
  localparam logic [7:0] PORT_CNT2   = 8'h0e;
  localparam logic [7:0] PORT_CTRL   = 8'h0f;

  // Enable bits in the port 02h byte
  localparam int unsigned EnBitCh0 = 3;
  localparam int unsigned EnBitCh1 = 6;
  localparam int unsigned EnBitCh2 = 7;

  // Count modes
  localparam logic [2:0] MODE_TERM_CNT  = 3'd0;
  localparam logic [2:0] MODE_ONE_SHOT  = 3'd1;
  localparam logic [2:0] MODE_RATE      = 3'd2;
  localparam logic [2:0] MODE_SQUARE    = 3'd3;
  localparam logic [2:0] MODE_SW_STROBE = 3'd4;
  localparam logic [2:0] MODE_HW_STROBE = 3'd5;

  // Access modes
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LSB   = 2'd1;
  localparam logic [1:0] ACC_MSB   = 2'd2;
  localparam logic [1:0] ACC_WORD  = 2'd3;

  typedef enum logic [1:0] {
    CH_OP_NONE  = 2'd0,
    CH_OP_TICK  = 2'd1,
    CH_OP_COUNT = 2'd2,
    CH_OP_CTRL  = 2'd3
  } chan_op_e;

  typedef struct packed {
    chan_op_e   op;
    logic [7:0] data;
  } chan_ctl_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] port;
    logic [7:0] data;
  } tcps_in_t;

  typedef struct packed {
    logic        out_zero;
    logic        out_one;
    logic        out_two;
    logic [1:0]  mix_level;
    logic [14:0] sample_level;
  } tcps_out_t;

endpackage

[rtl/tcps_chan.sv]
// One 8253-style counter channel: control word, count load and tick update.
`timescale 1ns / 1ps

module tcps_chan import tcps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  chan_ctl_t ctl_i,
  output logic      out_next_o
);

  typedef struct packed {
    logic [2:0]  count_mode;
    logic [1:0]  access_mode;
    logic        bcd_select;
    logic        byte_phase;
    logic [7:0]  low_byte_hold;
    logic [15:0] reload_value;
    logic [15:0] pending_value;
    logic        pending_flag;
    logic        out_level;
    logic        running;
    logic [16:0] countdown;
    logic        trigger_flag;
    logic        pulse_phase;
    logic        load_flag;
  } chan_state_t;

  chan_state_t st_q, st_d;

  // Zero means a full period: 10000 in BCD, 65536 in binary
  function automatic logic [16:0] eff_count(logic bcd, logic [15:0] v);
    logic [16:0] n;
    begin
      if (bcd) begin
        n = 17'(v[3:0]) + 17'(v[7:4]) * 17'd10 + 17'(v[11:8]) * 17'd100
            + 17'(v[15:12]) * 17'd1000;
      end else begin
        n = {1'b0, v};
      end
      if (n == 17'd0) begin
        n = bcd ? 17'd10000 : 17'd65536;
      end
      return n;
    end
  endfunction

  // Odd counts make the high half longer than the low half
  function automatic chan_state_t square_half(chan_state_t c);
    logic [16:0] n;
    logic [16:0] h;
    begin
      n = eff_count(c.bcd_select, c.reload_value);
      if (n < 17'd2) begin
        n = 17'd2;
      end
      if (n[0]) begin
        h = c.out_level ? ((n + 17'd1) >> 1) : ((n - 17'd1) >> 1);
        if (h == 17'd0) begin
          h = 17'd1;
        end
      end else begin
        h = n >> 1;
      end
      c.countdown = h;
      c.running   = 1'b1;
      return c;
    end
  endfunction

  function automatic chan_state_t load_counter(chan_state_t c);
    logic [16:0] n;
    begin
      if (c.pending_flag) begin
        c.reload_value = c.pending_value;
        c.pending_flag = 1'b0;
      end
      c.load_flag = 1'b0;
      c.running   = 1'b1;
      n = eff_count(c.bcd_select, c.reload_value);
      case (c.count_mode)
        MODE_TERM_CNT: begin
          c.out_level = 1'b0; c.pulse_phase = 1'b0; c.countdown = n;
        end
        MODE_ONE_SHOT: begin
          c.out_level = 1'b0; c.pulse_phase = 1'b1; c.countdown = n;
        end
        MODE_RATE: begin
          c.out_level = 1'b1; c.pulse_phase = 1'b0;
          c.countdown = (n > 17'd1) ? n - 17'd1 : 17'd1;
        end
        MODE_SQUARE: begin
          c.out_level = 1'b1;
          c = square_half(c);
        end
        MODE_SW_STROBE, MODE_HW_STROBE: begin
          c.out_level = 1'b1; c.pulse_phase = 1'b0; c.countdown = n;
        end
        default: begin
          c.running = 1'b0; c.countdown = 17'd0;
        end
      endcase
      return c;
    end
  endfunction

  function automatic chan_state_t transition(chan_state_t c);
    logic [16:0] n;
    begin
      n = eff_count(c.bcd_select, c.reload_value);
      if (c.load_flag) begin
        if (c.count_mode == MODE_ONE_SHOT || c.count_mode == MODE_HW_STROBE) begin
          c.trigger_flag = 1'b0;
        end
        c = load_counter(c);
      end else begin
        case (c.count_mode)
          MODE_TERM_CNT: begin
            c.out_level = 1'b1; c.running = 1'b0; c.countdown = 17'd0;
          end
          MODE_ONE_SHOT: begin
            c.out_level = 1'b1; c.running = 1'b0; c.pulse_phase = 1'b0;
            c.countdown = 17'd0;
          end
          MODE_RATE: begin
            if (!c.pulse_phase) begin
              c.out_level = 1'b0; c.pulse_phase = 1'b1; c.countdown = 17'd1;
            end else if (c.pending_flag) begin
              c = load_counter(c);
            end else begin
              c.out_level = 1'b1; c.pulse_phase = 1'b0;
              c.countdown = (n > 17'd1) ? n - 17'd1 : 17'd1;
              c.running = 1'b1;
            end
          end
          MODE_SQUARE: begin
            c.out_level = ~c.out_level;
            if (c.pending_flag) begin
              c.reload_value = c.pending_value;
              c.pending_flag = 1'b0;
            end
            c = square_half(c);
          end
          MODE_SW_STROBE, MODE_HW_STROBE: begin
            if (!c.pulse_phase) begin
              c.out_level = 1'b0; c.pulse_phase = 1'b1; c.countdown = 17'd1;
              c.running = 1'b1;
            end else begin
              c.out_level = 1'b1; c.pulse_phase = 1'b0; c.running = 1'b0;
              c.countdown = 17'd0;
              if (c.count_mode == MODE_HW_STROBE && c.pending_flag) begin
                c.load_flag = 1'b1; c.trigger_flag = 1'b1; c.countdown = 17'd1;
              end
            end
          end
          default: begin
            c.running = 1'b0; c.countdown = 17'd0;
          end
        endcase
      end
      return c;
    end
  endfunction

  function automatic chan_state_t commit(chan_state_t c, logic [15:0] v);
    begin
      c.pending_value = v;
      c.pending_flag  = 1'b1;
      case (c.count_mode)
        MODE_TERM_CNT: begin
          c.out_level = 1'b0; c.running = 1'b0; c.load_flag = 1'b1;
          c.countdown = 17'd1;
        end
        MODE_ONE_SHOT, MODE_HW_STROBE: begin
          c.trigger_flag = 1'b1; c.load_flag = 1'b1; c.countdown = 17'd1;
        end
        MODE_RATE, MODE_SQUARE: begin
          if (!c.running) begin
            c.load_flag = 1'b1; c.countdown = 17'd1;
          end
        end
        MODE_SW_STROBE: begin
          c.load_flag = 1'b1; c.countdown = 17'd1;
        end
        default: ;
      endcase
      return c;
    end
  endfunction

  function automatic chan_state_t write_count(chan_state_t c, logic [7:0] d);
    begin
      case (c.access_mode)
        ACC_LSB: c = commit(c, {8'h00, d});
        ACC_MSB: c = commit(c, {d, 8'h00});
        ACC_WORD: begin
          if (!c.byte_phase) begin
            c.low_byte_hold = d;
            c.byte_phase    = 1'b1;
          end else begin
            c.byte_phase = 1'b0;
            c = commit(c, {d, c.low_byte_hold});
          end
        end
        default: ;
      endcase
      return c;
    end
  endfunction

  function automatic chan_state_t write_control(chan_state_t c, logic [7:0] d);
    logic [2:0] m;
    begin
      m = d[3:1];
      // Modes 6 and 7 alias rate and square
      if (m[2] && m[1]) begin
        m = m - 3'd4;
      end
      if (d[5:4] != ACC_LATCH) begin
        c.access_mode   = d[5:4];
        c.count_mode    = m;
        c.bcd_select    = d[0];
        c.byte_phase    = 1'b0;
        c.low_byte_hold = 8'h00;
        c.pending_flag  = 1'b0;
        c.running       = 1'b0;
        c.load_flag     = 1'b0;
        c.trigger_flag  = 1'b0;
        c.pulse_phase   = 1'b0;
        c.countdown     = 17'd0;
        c.out_level     = (m != MODE_TERM_CNT);
      end
      return c;
    end
  endfunction

  always_comb begin
    st_d = st_q;
    case (ctl_i.op)
      CH_OP_TICK: begin
        if (st_d.countdown != 17'd0) begin
          st_d.countdown = st_d.countdown - 17'd1;
        end
        if ((st_d.running || st_d.load_flag) && st_d.countdown == 17'd0) begin
          st_d = transition(st_d);
          if ((st_d.running || st_d.load_flag) && st_d.countdown == 17'd0) begin
            st_d.countdown = 17'd1;
          end
        end
      end
      CH_OP_COUNT: st_d = write_count(st_q, ctl_i.data);
      CH_OP_CTRL:  st_d = write_control(st_q, ctl_i.data);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign out_next_o = st_d.out_level;

endmodule

[rtl/three_channel_pit_sound_top.sv]
// Top level of the three-channel interval timer tone source.
`timescale 1ns / 1ps
`include "three_channel_pit_sound_top_defines.svh"

// Three 8253-style counters used as a tone source. Each input transaction is
// either a port write (kind 0: port 02h output enables, 0Ch-0Eh count bytes,
// 0Fh control word) or one timer input clock (kind 1), and each one yields
// exactly one result transaction carrying the three channel output levels
// after that step, the number of enabled high outputs and that number times
// the channel gain (saturated at 32767). One transaction is taken every
// clock while the result side is not stalled; the transaction waits in the
// input register and is then captured, fully processed, in the result
// register. The rate is set by the single-pass channel update, which
// applies a whole step to all three counters at once. The gain register
// is written through cfg_we_i / cfg_data_i and resets to 3584; write it
// only while no result is pending.
module three_channel_pit_sound_top import tcps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcps_in_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tcps_out_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [GainW-1:0] cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  tcps_in_t         in_q;
  logic             out_valid_q, out_valid_d;
  tcps_out_t        out_q, out_d;
  logic [GainW-1:0] gain_q;
  logic [2:0]       en_q, en_d;

  logic             advance;
  logic             proc_fire;
  logic             in_accept;
  chan_ctl_t        ctl [NumChan];
  logic [2:0]       lvl;
  logic [2:0]       hot;
  logic [1:0]       mix;
  logic [15:0]      prod;

  // Hand on the held transaction once the result register is free or draining
  assign advance    = !out_valid_q || !out_stall_i;
  assign proc_fire  = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (proc_fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  // Decode the held transaction into one command per channel
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      ctl[i].op   = CH_OP_NONE;
      ctl[i].data = in_q.data;
    end
    if (proc_fire) begin
      if (in_q.kind == KIND_TICK) begin
        for (int i = 0; i < NumChan; i++) begin
          ctl[i].op = CH_OP_TICK;
        end
      end else begin
        case (in_q.port)
          PORT_CNT0: ctl[0].op = CH_OP_COUNT;
          PORT_CNT1: ctl[1].op = CH_OP_COUNT;
          PORT_CNT2: ctl[2].op = CH_OP_COUNT;
          PORT_CTRL: begin
            // Select 3 addresses no channel and drops out here
            case (in_q.data[7:6])
              2'd0:    ctl[0].op = CH_OP_CTRL;
              2'd1:    ctl[1].op = CH_OP_CTRL;
              2'd2:    ctl[2].op = CH_OP_CTRL;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  for (genvar g = 0; g < NumChan; g++) begin : g_chan
    tcps_chan u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl[g]),
      .out_next_o (lvl[g])
    );
  end

  // Output enables from port 02h
  always_comb begin
    en_d = en_q;
    if (proc_fire && in_q.kind == KIND_WRITE && in_q.port == PORT_ENABLE) begin
      en_d = {in_q.data[EnBitCh2], in_q.data[EnBitCh1], in_q.data[EnBitCh0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else begin
      en_q <= en_d;
    end
  end

  // Mix the enabled high outputs and scale by the gain, saturating
  assign hot  = lvl & en_d;
  assign mix  = 2'({1'b0, hot[0]} + {1'b0, hot[1]} + {1'b0, hot[2]});
  assign prod = 16'(mix) * 16'(gain_q);

  always_comb begin
    out_d.out_zero     = lvl[0];
    out_d.out_one      = lvl[1];
    out_d.out_two      = lvl[2];
    out_d.mix_level    = mix;
    out_d.sample_level = prod[15] ? 15'h7fff : prod[14:0];
  end

  always_comb begin
    if (proc_fire) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_we_i) begin
      gain_q <= cfg_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Hold the input side only while a result waits on a stalled consumer
  `TCPS_ASSERT_IMP(a_stall_only_when_blocked, in_stall_o, out_valid_o && out_stall_i)
  // Every processed transaction lands in the result register
  `TCPS_ASSERT_NXT(a_fire_gives_result, proc_fire, out_valid_o)
  // No enabled high output means silence
  `TCPS_ASSERT_IMP(a_silent_when_unmixed, out_valid_o && out_item_o.mix_level == 2'd0, out_item_o.sample_level == 15'd0)
  // The mix never counts more channels than are high
  `TCPS_ASSERT_IMP(a_mix_bounded, out_valid_o, out_item_o.mix_level <= 2'({1'b0, out_item_o.out_zero} + {1'b0, out_item_o.out_one} + {1'b0, out_item_o.out_two}))

endmodule

[tb/tcps_level_checker.sv]
// Result checker for the three-channel interval timer tone source.
`timescale 1ns / 1ps

module tcps_level_checker import tcps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  tcps_in_t         in_item_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  tcps_out_t        out_item_i,
  input  logic             cfg_we_i,
  input  logic [GainW-1:0] cfg_data_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_count_o,
  output int unsigned      checked_count_o
);

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  access;
    logic        bcd;
    logic        phase_hi;
    logic [7:0]  lo_hold;
    logic [15:0] reload;
    logic [15:0] pending;
    logic        pend_f;
    logic        level;
    logic        running;
    logic [16:0] remain;
    logic        trig;
    logic        pulse;
    logic        load_f;
  } timer_ch_t;

  timer_ch_t          timers [NumChan];
  logic [NumChan-1:0] enables;
  logic [GainW-1:0]   gain;
  tcps_out_t          expected_levels [$];
  tcps_out_t          want;

  // Whole clocks for a programmed count; zero wraps to the full range.
  function automatic int unsigned count_span(input logic bcd, input logic [15:0] v);
    int unsigned n;
    if (bcd) begin
      n = v[3:0] + v[7:4] * 10 + v[11:8] * 100 + v[15:12] * 1000;
    end else begin
      n = v;
    end
    if (n == 0) n = bcd ? 10000 : 65536;
    return n;
  endfunction

  // Odd counts make the high half the longer one.
  function automatic timer_ch_t square_half(input timer_ch_t c);
    int unsigned n, h;
    n = count_span(c.bcd, c.reload);
    if (n < 2) n = 2;
    if (n % 2 == 1) begin
      h = c.level ? (n + 1) / 2 : (n - 1) / 2;
      if (h < 1) h = 1;
    end else begin
      h = n / 2;
    end
    c.remain  = 17'(h);
    c.running = 1'b1;
    return c;
  endfunction

  function automatic timer_ch_t load_counter(input timer_ch_t c);
    int unsigned n;
    if (c.pend_f) begin
      c.reload = c.pending;
      c.pend_f = 1'b0;
    end
    c.load_f  = 1'b0;
    c.running = 1'b1;
    n = count_span(c.bcd, c.reload);
    case (c.mode)
      MODE_TERM_CNT: begin
        c.level = 1'b0; c.pulse = 1'b0; c.remain = 17'(n);
      end
      MODE_ONE_SHOT: begin
        c.level = 1'b0; c.pulse = 1'b1; c.remain = 17'(n);
      end
      MODE_RATE: begin
        c.level = 1'b1; c.pulse = 1'b0; c.remain = (n > 1) ? 17'(n - 1) : 17'd1;
      end
      MODE_SQUARE: begin
        c.level = 1'b1;
        c = square_half(c);
      end
      MODE_SW_STROBE, MODE_HW_STROBE: begin
        c.level = 1'b1; c.pulse = 1'b0; c.remain = 17'(n);
      end
      default: begin
        c.running = 1'b0; c.remain = '0;
      end
    endcase
    return c;
  endfunction

  // What happens when a running or loading channel reaches zero.
  function automatic timer_ch_t terminal_count(input timer_ch_t c);
    int unsigned n;
    if (c.load_f) begin
      if (c.mode == MODE_ONE_SHOT || c.mode == MODE_HW_STROBE) c.trig = 1'b0;
      return load_counter(c);
    end
    case (c.mode)
      MODE_TERM_CNT: begin
        c.level = 1'b1; c.running = 1'b0; c.remain = '0;
      end
      MODE_ONE_SHOT: begin
        c.level = 1'b1; c.running = 1'b0; c.pulse = 1'b0; c.remain = '0;
      end
      MODE_RATE: begin
        if (!c.pulse) begin
          c.level = 1'b0; c.pulse = 1'b1; c.remain = 17'd1;
        end else if (c.pend_f) begin
          c = load_counter(c);
        end else begin
          c.level = 1'b1; c.pulse = 1'b0;
          n = count_span(c.bcd, c.reload);
          c.remain  = (n > 1) ? 17'(n - 1) : 17'd1;
          c.running = 1'b1;
        end
      end
      MODE_SQUARE: begin
        c.level = ~c.level;
        if (c.pend_f) begin
          c.reload = c.pending;
          c.pend_f = 1'b0;
        end
        c = square_half(c);
      end
      MODE_SW_STROBE, MODE_HW_STROBE: begin
        if (!c.pulse) begin
          c.level = 1'b0; c.pulse = 1'b1; c.remain = 17'd1; c.running = 1'b1;
        end else begin
          c.level = 1'b1; c.pulse = 1'b0; c.running = 1'b0; c.remain = '0;
          if (c.mode == MODE_HW_STROBE && c.pend_f) begin
            c.load_f = 1'b1; c.trig = 1'b1; c.remain = 17'd1;
          end
        end
      end
      default: begin
        c.running = 1'b0; c.remain = '0;
      end
    endcase
    return c;
  endfunction

  function automatic timer_ch_t commit_count(input timer_ch_t c, input logic [15:0] v);
    c.pending = v;
    c.pend_f  = 1'b1;
    case (c.mode)
      MODE_TERM_CNT: begin
        c.level = 1'b0; c.running = 1'b0; c.load_f = 1'b1; c.remain = 17'd1;
      end
      MODE_ONE_SHOT, MODE_HW_STROBE: begin
        c.trig = 1'b1; c.load_f = 1'b1; c.remain = 17'd1;
      end
      MODE_RATE, MODE_SQUARE: begin
        if (!c.running) begin
          c.load_f = 1'b1; c.remain = 17'd1;
        end
      end
      MODE_SW_STROBE: begin
        c.load_f = 1'b1; c.remain = 17'd1;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic timer_ch_t count_byte(input timer_ch_t c, input logic [7:0] d);
    case (c.access)
      ACC_LSB: c = commit_count(c, {8'h00, d});
      ACC_MSB: c = commit_count(c, {d, 8'h00});
      ACC_WORD: begin
        if (!c.phase_hi) begin
          c.lo_hold  = d;
          c.phase_hi = 1'b1;
        end else begin
          c.phase_hi = 1'b0;
          c = commit_count(c, {d, c.lo_hold});
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic timer_ch_t control_word(input timer_ch_t c, input logic [7:0] d);
    logic [2:0] m;
    m = d[3:1];
    if (d[5:4] == ACC_LATCH) return c;
    if (m > MODE_HW_STROBE) m = m - 3'd4;
    c.access   = d[5:4];
    c.mode     = m;
    c.bcd      = d[0];
    c.phase_hi = 1'b0;
    c.lo_hold  = '0;
    c.pend_f   = 1'b0;
    c.running  = 1'b0;
    c.load_f   = 1'b0;
    c.trig     = 1'b0;
    c.pulse    = 1'b0;
    c.remain   = '0;
    c.level    = (m != MODE_TERM_CNT);
    return c;
  endfunction

  // Advance the timer copy by one transaction and return the levels it shows.
  function automatic tcps_out_t mix_after_step(input tcps_in_t it);
    int unsigned mix, s;
    tcps_out_t   r;
    if (it.kind == KIND_WRITE) begin
      if (it.port == PORT_ENABLE) begin
        enables = {it.data[EnBitCh2], it.data[EnBitCh1], it.data[EnBitCh0]};
      end else if (it.port == PORT_CNT0) begin
        timers[0] = count_byte(timers[0], it.data);
      end else if (it.port == PORT_CNT1) begin
        timers[1] = count_byte(timers[1], it.data);
      end else if (it.port == PORT_CNT2) begin
        timers[2] = count_byte(timers[2], it.data);
      end else if (it.port == PORT_CTRL && int'(it.data[7:6]) < NumChan) begin
        timers[it.data[7:6]] = control_word(timers[it.data[7:6]], it.data);
      end
    end else begin
      for (int i = 0; i < NumChan; i++) begin
        if (timers[i].remain != '0) timers[i].remain = timers[i].remain - 17'd1;
      end
      for (int i = 0; i < NumChan; i++) begin
        if ((timers[i].running || timers[i].load_f) && timers[i].remain == '0) begin
          timers[i] = terminal_count(timers[i]);
          if ((timers[i].running || timers[i].load_f) && timers[i].remain == '0)
            timers[i].remain = 17'd1;
        end
      end
    end
    mix = 0;
    for (int i = 0; i < NumChan; i++) begin
      if (enables[i] && timers[i].level) mix++;
    end
    s = mix * gain;
    if (s > 32767) s = 32767;
    r.out_zero     = timers[0].level;
    r.out_one      = timers[1].level;
    r.out_two      = timers[2].level;
    r.mix_level    = 2'(mix);
    r.sample_level = 15'(s);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [14:0] exp_v,
                             input logic [14:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) timers[i] = '0;
      enables = '0;
      gain    = GainReset;
      expected_levels.delete();
      mismatch_count_o = 0;
      checked_count_o  = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_we_i) gain = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          $error("result with no expectation waiting: %h", out_item_i);
          mismatch_count_o++;
        end else begin
          want = expected_levels.pop_front();
          check_field("out_zero", 15'(want.out_zero), 15'(out_item_i.out_zero));
          check_field("out_one", 15'(want.out_one), 15'(out_item_i.out_one));
          check_field("out_two", 15'(want.out_two), 15'(out_item_i.out_two));
          check_field("mix_level", 15'(want.mix_level), 15'(out_item_i.mix_level));
          check_field("sample_level", want.sample_level, out_item_i.sample_level);
          checked_count_o++;
        end
      end
      if (in_valid_i && !in_stall_i) expected_levels.push_back(mix_after_step(in_item_i));
      pending_count_o = expected_levels.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the testbench for the three-channel interval timer tone source.
`timescale 1ns / 1ps

// The stimulus here programs the three counters through their ports and clocks
// them with tick transactions; the checker beside the block predicts every
// result and compares it. This module only drives stimulus, runs the watchdog
// and gives the verdict.
module tb_top;
  import tcps_pkg::*;

  localparam int unsigned QuietLimit     = 4000;  // cycles with no handshake at all
  localparam int unsigned NumStages      = 6;
  localparam int unsigned ItemsPerStage  = 200;
  localparam int unsigned SettleCycles   = 8;     // extra idle time after the last result

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  tcps_in_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  tcps_out_t        out_item_o;
  logic             cfg_we_i    = 1'b0;
  logic [GainW-1:0] cfg_data_i  = '0;

  int unsigned mismatches;
  int unsigned in_flight;
  int unsigned results_checked;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned item_count    = 0;   // ticks and decoded port writes only
  int unsigned tick_count    = 0;
  int unsigned write_count   = 0;

  // Our idea of how each channel was last programmed, so that count bytes
  // come in the number the access mode wants. Noise may make it stale.
  logic [1:0] acc_of [NumChan];
  logic       bcd_of [NumChan];

  three_channel_pit_sound_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  tcps_level_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_i       (out_item_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_count_o  (in_flight),
    .checked_count_o  (results_checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure: redraw the stall at every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: give up once neither channel has moved a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Offer one transaction, with an optional random gap first, and hold it
  // until it is taken. Enter and leave just after a falling edge.
  task automatic send_item(input logic kind, input logic [7:0] port, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    in_item_i.kind = kind;
    in_item_i.port = port;
    in_item_i.data = data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (kind == KIND_TICK) tick_count++;
    else write_count++;
    if (kind == KIND_TICK || port == PORT_ENABLE || (port >= PORT_CNT0 && port <= PORT_CTRL))
      item_count++;
  endtask

  // Ticks carry random port and data bits; the block must ignore them.
  task automatic tick_run(input int unsigned n);
    repeat (n) send_item(KIND_TICK, 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (in_flight != 0) @(negedge clk_i);
  endtask

  task automatic set_gain(input int unsigned g);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_data_i = GainW'(g);
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // Load a count in whatever byte order the channel expects. Mostly short
  // counts so that terminal counts actually happen; now and then zero, odd
  // BCD digits or a full random word.
  task automatic load_count(input int unsigned ch);
    logic [7:0]  port;
    logic [15:0] v;
    int unsigned pick, n;
    port = PORT_CNT0 + 8'(ch);
    pick = $urandom_range(99);
    n    = $urandom_range(1, 12);
    if (pick < 70) v = bcd_of[ch] ? 16'(((n / 10) << 4) | (n % 10)) : 16'(n);
    else if (pick < 78) v = '0;
    else if (pick < 90) v = 16'($urandom_range(13, 80));
    else v = 16'($urandom);
    case (acc_of[ch])
      ACC_LSB: send_item(KIND_WRITE, port, v[7:0]);
      ACC_MSB: send_item(KIND_WRITE, port, (pick < 90) ? 8'($urandom_range(1, 2)) : v[15:8]);
      ACC_WORD: begin
        send_item(KIND_WRITE, port, v[7:0]);
        // Drop the high byte now and then to leave the pair half written.
        if ($urandom_range(19) != 0) send_item(KIND_WRITE, port, v[15:8]);
      end
      default: send_item(KIND_WRITE, port, v[7:0]);
    endcase
  endtask

  task automatic program_channel(output int unsigned ch);
    logic [1:0] acc;
    logic [2:0] mode;
    logic       bcd;
    ch   = $urandom_range(NumChan - 1);
    acc  = 2'($urandom_range(int'(ACC_LSB), int'(ACC_WORD)));
    mode = 3'($urandom_range(7));
    bcd  = ($urandom_range(3) == 0);
    send_item(KIND_WRITE, PORT_CTRL, {2'(ch), acc, mode, bcd});
    acc_of[ch] = acc;
    bcd_of[ch] = bcd;
  endtask

  // One burst of random stimulus: mostly a full program-load-clock sequence,
  // the rest enable writes, raw control words, stray ports and lone bytes.
  task automatic run_burst();
    int unsigned pick, ch;
    logic [7:0]  raw;
    pick = $urandom_range(99);
    if (pick < 78) begin
      program_channel(ch);
      load_count(ch);
      tick_run($urandom_range(1, 30));
      if ($urandom_range(2) == 0) begin
        // Reload mid-count to exercise the pending value in each mode.
        load_count(ch);
        tick_run($urandom_range(1, 30));
      end
    end else if (pick < 86) begin
      send_item(KIND_WRITE, PORT_ENABLE,
                8'($urandom) | ($urandom_range(1) ? 8'hc8 : 8'h00));
    end else if (pick < 92) begin
      raw = 8'($urandom);
      send_item(KIND_WRITE, PORT_CTRL, raw);
      if (int'(raw[7:6]) < NumChan && raw[5:4] != ACC_LATCH) begin
        acc_of[raw[7:6]] = raw[5:4];
        bcd_of[raw[7:6]] = raw[0];
      end
    end else if (pick < 96) begin
      send_item(KIND_WRITE, 8'($urandom), 8'($urandom));
    end else begin
      send_item(KIND_WRITE, PORT_CNT0 + 8'($urandom_range(NumChan - 1)), 8'($urandom));
      tick_run($urandom_range(1, 5));
    end
  endtask

  initial begin
    int unsigned gain_plan  [NumStages];
    int unsigned idle_plan  [NumStages];
    int unsigned stall_plan [NumStages];
    int unsigned stage_end;

    // Stage 0 keeps the reset gain; the rest sweep full scale, zero,
    // beyond full scale (saturating), a random value and the smallest step.
    gain_plan  = '{3584, 10922, 0, 16383, 0, 1};
    gain_plan[4] = $urandom_range(10922);
    idle_plan  = '{0, 56, 0, 21, 56, 21};
    stall_plan = '{0, 0, 56, 21, 0, 21};
    for (int i = 0; i < NumChan; i++) begin
      acc_of[i] = ACC_LATCH;
      bcd_of[i] = 1'b0;
    end

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed opening. Count bytes before any control word must be ignored.
    send_item(KIND_WRITE, PORT_CNT0, 8'h12);
    send_item(KIND_WRITE, PORT_ENABLE, 8'hc8);      // all three outputs enabled
    send_item(KIND_WRITE, 8'h00, 8'h00);            // undecoded ports, extreme values
    send_item(KIND_WRITE, 8'hff, 8'hff);
    send_item(KIND_WRITE, PORT_CTRL, 8'hf6);        // select 3: ignored
    send_item(KIND_WRITE, PORT_CTRL, 8'h00);        // counter latch on ch0: ignored
    // ch1: word access, mode 7 folding to square wave, BCD, zero count = 10000
    send_item(KIND_WRITE, PORT_CTRL, 8'h7f);
    send_item(KIND_WRITE, PORT_CNT1, 8'h00);
    send_item(KIND_WRITE, PORT_CNT1, 8'h00);
    // ch0: word access, terminal count, binary zero count = 65536
    send_item(KIND_WRITE, PORT_CTRL, 8'h30);
    send_item(KIND_WRITE, PORT_CNT0, 8'h00);
    send_item(KIND_WRITE, PORT_CNT0, 8'h00);
    // ch2: word access, mode 6 folding to rate generator, BCD digits all above 9
    send_item(KIND_WRITE, PORT_CTRL, 8'hbd);
    send_item(KIND_WRITE, PORT_CNT2, 8'hff);
    send_item(KIND_WRITE, PORT_CNT2, 8'hff);
    // ch0: LSB only, one-shot with a count of 3
    send_item(KIND_WRITE, PORT_CTRL, 8'h12);
    send_item(KIND_WRITE, PORT_CNT0, 8'h03);
    tick_run(5);
    // ch1: MSB only, rate generator of 256
    send_item(KIND_WRITE, PORT_CTRL, 8'h64);
    send_item(KIND_WRITE, PORT_CNT1, 8'h01);
    tick_run(3);

    for (int s = 0; s < NumStages; s++) begin
      if (s != 0) set_gain(gain_plan[s]);
      send_idle_pct = idle_plan[s];
      stall_pct     = stall_plan[s];
      stage_end     = item_count + ItemsPerStage;
      while (item_count < stage_end - ItemsPerStage / 2) run_burst();
      // Hold off once, mid-stage, until every outstanding result has arrived.
      if (s == 3) drain_results();
      while (item_count < stage_end) run_burst();
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);

    $display("Covered %0d transactions (%0d ticks, %0d port writes); %0d results checked",
             tick_count + write_count, tick_count, write_count, results_checked);
    $display("over six gain settings from 0 to 16383 and four sender/receiver idling mixes");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[three_channel_pit_sound_top.f]
+incdir+rtl
rtl/tcps_pkg.sv
rtl/tcps_chan.sv
rtl/three_channel_pit_sound_top.sv
tb/tcps_level_checker.sv
tb/tb_top.sv
